// File: hw/rtl/rgb565_blend_pixel_writer_top_defines.svh
// Assertion macros of the pixel writer top level
`ifndef RGB565_BLEND_PIXEL_WRITER_TOP_DEFINES_SVH
`define RGB565_BLEND_PIXEL_WRITER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define RBW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbw check failed");

`define RBW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbw check failed");

`else

`define RBW_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define RBW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/rbw_pkg.sv
// Types, constants and the division step helper function of the RGB565 blend pixel writer
package rbw_pkg;

    localparam int FIELD_W          = 16;
    localparam int ADDR_W           = 20;
    localparam int DIV_W            = 8;
    localparam int CFG_IDX_W        = 1;
    localparam int DVD_W            = 7;
    localparam int REM_W            = DIV_W;
    localparam int NUM_CELLS        = DVD_W;
    localparam int RB_W             = 5;
    localparam int G_W              = 6;
    localparam int DEF_SCREEN_WIDTH  = 1024;
    localparam int DEF_SCREEN_HEIGHT = 768;

    localparam logic [RB_W-1:0]  RB_MAX = 5'h1F;
    localparam logic [G_W-1:0]   G_MAX  = 6'h3F;
    localparam logic [DIV_W-1:0] DIVISOR_RESET = 8'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ENABLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_DIVISOR = 1'b1;

    typedef struct packed {
        logic               on_screen;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] fg;
    } pix_meta_t;

    typedef struct packed {
        logic [DVD_W-1:0] dvd;
        logic [REM_W-1:0] rem;
        logic [DVD_W-1:0] quo;
    } chan_div_t;

    typedef struct packed {
        pix_meta_t meta;
        chan_div_t red;
        chan_div_t green;
        chan_div_t blue;
    } stage_word_t;

    function automatic chan_div_t div_step(chan_div_t cur, logic [DIV_W-1:0] divisor);
        logic [REM_W:0] trial;
        chan_div_t      nxt;
        trial   = {cur.rem, cur.dvd[DVD_W-1]};
        nxt.dvd = {cur.dvd[DVD_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor})
        begin
            nxt.rem = REM_W'(trial - {1'b0, divisor});
            nxt.quo = {cur.quo[DVD_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem = trial[REM_W-1:0];
            nxt.quo = {cur.quo[DVD_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

// File: hw/rtl/rbw_pix_in_if.sv
// Pixel input channel interface
interface rbw_pix_in_if
    import rbw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] rect_left;
    logic [FIELD_W-1:0] rect_top;
    logic [FIELD_W-1:0] offset_x;
    logic [FIELD_W-1:0] offset_y;
    logic [FIELD_W-1:0] fg_color;
    logic [FIELD_W-1:0] bg_pixel;

    modport source (
        output valid, rect_left, rect_top, offset_x, offset_y, fg_color, bg_pixel,
        input  ready
    );

    modport sink (
        input  valid, rect_left, rect_top, offset_x, offset_y, fg_color, bg_pixel,
        output ready
    );
endinterface

// File: hw/rtl/rbw_pix_out_if.sv
// Pixel write output channel interface
interface rbw_pix_out_if
    import rbw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               write_enable;
    logic [ADDR_W-1:0]  pixel_address;
    logic [FIELD_W-1:0] pixel_value;

    modport source (
        output valid, write_enable, pixel_address, pixel_value,
        input  ready
    );

    modport sink (
        input  valid, write_enable, pixel_address, pixel_value,
        output ready
    );
endinterface

// File: hw/rtl/rbw_cfg_if.sv
// Configuration write channel interface
interface rbw_cfg_if
    import rbw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIV_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: hw/rtl/rbw_front.sv
// Entry stage: screen position, on-screen check and channel sums
module rbw_front
    import rbw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] rect_left,
    input  logic [FIELD_W-1:0] rect_top,
    input  logic [FIELD_W-1:0] offset_x,
    input  logic [FIELD_W-1:0] offset_y,
    input  logic [FIELD_W-1:0] fg_color,
    input  logic [FIELD_W-1:0] bg_pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output stage_word_t        out_word
);

    logic        valid_reg;
    stage_word_t word_reg;
    stage_word_t word_next;
    logic [FIELD_W-1:0] x_sum;
    logic [FIELD_W-1:0] y_sum;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        x_sum = rect_left + offset_x;
        y_sum = rect_top + offset_y;
        word_next.meta.x  = x_sum;
        word_next.meta.y  = y_sum;
        word_next.meta.fg = fg_color;
        word_next.meta.on_screen = (x_sum < FIELD_W'(SCREEN_WIDTH)) &&
                                   (y_sum < FIELD_W'(SCREEN_HEIGHT));
        word_next.red.dvd   = DVD_W'(fg_color[15:11]) + DVD_W'(bg_pixel[15:11]);
        word_next.green.dvd = DVD_W'(fg_color[10:5]) + DVD_W'(bg_pixel[10:5]);
        word_next.blue.dvd  = DVD_W'(fg_color[4:0]) + DVD_W'(bg_pixel[4:0]);
        word_next.red.rem   = '0;
        word_next.green.rem = '0;
        word_next.blue.rem  = '0;
        word_next.red.quo   = '0;
        word_next.green.quo = '0;
        word_next.blue.quo  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: hw/rtl/rbw_div_cell.sv
// Divider cell: one quotient bit per channel, then hand the word on
module rbw_div_cell
    import rbw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIV_W-1:0] divisor,
    input  logic             in_valid,
    output logic             in_ready,
    input  stage_word_t      in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output stage_word_t      out_word
);

    logic        valid_reg;
    stage_word_t word_reg;
    stage_word_t word_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        word_next.meta  = in_word.meta;
        word_next.red   = div_step(in_word.red, divisor);
        word_next.green = div_step(in_word.green, divisor);
        word_next.blue  = div_step(in_word.blue, divisor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: hw/rtl/rbw_out.sv
// Output stage: saturate channels or pass the foreground colour, form the address, hold the result word
module rbw_out
    import rbw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               blend_enable,
    input  logic               in_valid,
    output logic               in_ready,
    input  stage_word_t        in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               write_enable,
    output logic [ADDR_W-1:0]  pixel_address,
    output logic [FIELD_W-1:0] pixel_value
);

    localparam int XW     = $clog2(SCREEN_WIDTH);
    localparam int YW     = $clog2(SCREEN_HEIGHT);
    localparam int WW     = $clog2(SCREEN_WIDTH + 1);
    localparam int PROD_W = WW + YW + 1;
    localparam int ACC_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

    logic               valid_reg;
    logic               we_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [FIELD_W-1:0] value_reg;
    logic               we_next;
    logic [ADDR_W-1:0]  addr_next;
    logic [FIELD_W-1:0] value_next;
    logic [ACC_W-1:0]   addr_full;
    logic [RB_W-1:0]    red_sat;
    logic [G_W-1:0]     green_sat;
    logic [RB_W-1:0]    blue_sat;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        red_sat   = (in_word.red.quo > DVD_W'(RB_MAX)) ? RB_MAX : in_word.red.quo[RB_W-1:0];
        green_sat = (in_word.green.quo > DVD_W'(G_MAX)) ? G_MAX : in_word.green.quo[G_W-1:0];
        blue_sat  = (in_word.blue.quo > DVD_W'(RB_MAX)) ? RB_MAX : in_word.blue.quo[RB_W-1:0];
        addr_full = ACC_W'(in_word.meta.y[YW-1:0]) * ACC_W'(SCREEN_WIDTH) +
                    ACC_W'(in_word.meta.x[XW-1:0]);
        we_next = in_word.meta.on_screen;
        if (in_word.meta.on_screen)
        begin
            addr_next  = addr_full[ADDR_W-1:0];
            value_next = blend_enable ? {red_sat, green_sat, blue_sat} : in_word.meta.fg;
        end
        else
        begin
            addr_next  = '0;
            value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            we_reg    <= we_next;
            addr_reg  <= addr_next;
            value_reg <= value_next;
        end
    end

    assign out_valid     = valid_reg;
    assign write_enable  = we_reg;
    assign pixel_address = addr_reg;
    assign pixel_value   = value_reg;

endmodule

// File: hw/rtl/rgb565_blend_pixel_writer_top.sv
// Top level of the RGB565 blend pixel writer
// Path: an accepted input word passes the front register, the divider cells and the output register.
// Throughput: one word per cycle while pix_out.ready stays high; the chain of seven divider cells,
// one quotient bit each, sets the depth, and every cell takes a new word while the one ahead moves on.
// Reset: all stage valid bits clear, blend_enable resets to 0, blend_divisor to 2.
// Configuration writes are taken every cycle.
`include "rgb565_blend_pixel_writer_top_defines.svh"

module rgb565_blend_pixel_writer_top
    import rbw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic       clk,
    input  logic       rst_n,
    rbw_pix_in_if.sink   pix_in,
    rbw_pix_out_if.source pix_out,
    rbw_cfg_if.sink      cfg
);

    logic             blend_enable_reg;
    logic [DIV_W-1:0] divisor_reg;
    logic [DIV_W-1:0] divisor_eff;

    logic        chain_valid [NUM_CELLS+1];
    logic        chain_ready [NUM_CELLS+1];
    stage_word_t chain_word  [NUM_CELLS+1];

    assign cfg.ready   = 1'b1;
    assign divisor_eff = (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_enable_reg <= 1'b0;
            divisor_reg      <= DIVISOR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BLEND_ENABLE:  blend_enable_reg <= cfg.data[0];
                CFG_BLEND_DIVISOR: divisor_reg      <= cfg.data;
                default:           divisor_reg      <= divisor_reg;
            endcase
        end
    end

    rbw_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .rect_left (pix_in.rect_left),
        .rect_top  (pix_in.rect_top),
        .offset_x  (pix_in.offset_x),
        .offset_y  (pix_in.offset_y),
        .fg_color  (pix_in.fg_color),
        .bg_pixel  (pix_in.bg_pixel),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_word  (chain_word[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        rbw_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .divisor   (divisor_eff),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    rbw_out #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .blend_enable  (blend_enable_reg),
        .in_valid      (chain_valid[NUM_CELLS]),
        .in_ready      (chain_ready[NUM_CELLS]),
        .in_word       (chain_word[NUM_CELLS]),
        .out_valid     (pix_out.valid),
        .out_ready     (pix_out.ready),
        .write_enable  (pix_out.write_enable),
        .pixel_address (pix_out.pixel_address),
        .pixel_value   (pix_out.pixel_value)
    );

    `RBW_ASSERT_SAME(a_drop_zero, clk, rst_n, pix_out.valid && !pix_out.write_enable, (pix_out.pixel_address == '0) && (pix_out.pixel_value == '0))
    `RBW_ASSERT_NEXT(a_accept_front, clk, rst_n, pix_in.valid && pix_in.ready, chain_valid[0])
    `RBW_ASSERT_NEXT(a_last_to_out, clk, rst_n, chain_valid[NUM_CELLS] && chain_ready[NUM_CELLS], pix_out.valid)
    `RBW_ASSERT_SAME(a_divisor_nonzero, clk, rst_n, chain_valid[0], divisor_eff != '0)

endmodule

// File: tb/sv/tb_rgb565_blend_pixel_writer_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the RGB565 blend pixel writer: queued pixel words against predicted writes
module tb_rgb565_blend_pixel_writer_top;
    import rbw_pkg::*;

    localparam int SCREEN_W     = DEF_SCREEN_WIDTH;
    localparam int SCREEN_H     = DEF_SCREEN_HEIGHT;
    localparam int MAX_GAP      = 12;
    localparam int LONG_STALL   = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 250;

    typedef enum int {GAPS_RANDOM, GAPS_NONE, GAPS_SPARSE} idle_mode_t;

    typedef struct packed {
        logic [FIELD_W-1:0] rect_left, rect_top, offset_x, offset_y, fg_color, bg_pixel;
    } pixel_word_t;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  pixel_address;
        logic [FIELD_W-1:0] pixel_value;
    } pixel_write_t;

    typedef struct {
        pixel_word_t word;
        int          gap;
    } fill_job_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rbw_pix_in_if  pix_in_bus ();
    rbw_pix_out_if pix_out_bus ();
    rbw_cfg_if     cfg_bus ();

    rgb565_blend_pixel_writer_top #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus),
        .cfg     (cfg_bus)
    );

    fill_job_t        fill_queue [$];
    pixel_write_t     pending_writes [$];
    logic             blend_on_model;
    logic [DIV_W-1:0] divisor_model;
    idle_mode_t       idle_mode = GAPS_RANDOM;

    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;

    int fail_count       = 0;
    int writes_checked   = 0;
    int writes_on_screen = 0;
    int settings_used    = 1;

    fill_job_t drv_job;
    bit        drv_loaded = 1'b0;
    bit        drv_active = 1'b0;
    int        drv_wait   = 0;
    int        sink_wait  = 0;
    int        sink_taken = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int draw_gap(idle_mode_t mode);
        case (mode)
            GAPS_NONE:   return 0;
            GAPS_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
            default:     return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    function automatic pixel_word_t make_pixel(logic [FIELD_W-1:0] left, logic [FIELD_W-1:0] top,
                                               logic [FIELD_W-1:0] ox, logic [FIELD_W-1:0] oy,
                                               logic [FIELD_W-1:0] fg, logic [FIELD_W-1:0] bg);
        pixel_word_t p;
        p.rect_left = left;
        p.rect_top  = top;
        p.offset_x  = ox;
        p.offset_y  = oy;
        p.fg_color  = fg;
        p.bg_pixel  = bg;
        return p;
    endfunction

    function automatic logic [6:0] sat_channel(logic [6:0] sum, logic [DIV_W-1:0] d,
                                               logic [6:0] maxv);
        logic [DIV_W-1:0] q;
        q = {1'b0, sum} / d;
        return (q > {1'b0, maxv}) ? maxv : q[6:0];
    endfunction

    function automatic pixel_write_t predict_write(pixel_word_t p, logic blend_on,
                                                   logic [DIV_W-1:0] div);
        pixel_write_t     w;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [31:0]      lin;
        logic [DIV_W-1:0] d;
        logic [6:0]       r;
        logic [6:0]       g;
        logic [6:0]       b;
        x = p.rect_left + p.offset_x;
        y = p.rect_top + p.offset_y;
        w = '0;
        if (x < SCREEN_W && y < SCREEN_H)
        begin
            lin = 32'(x) + 32'(y) * SCREEN_W;
            w.write_enable  = 1'b1;
            w.pixel_address = lin[ADDR_W-1:0];
            if (blend_on)
            begin
                d = (div == '0) ? DIV_W'(1) : div;
                r = sat_channel(7'(p.fg_color[15:11]) + 7'(p.bg_pixel[15:11]), d, 7'(RB_MAX));
                g = sat_channel(7'(p.fg_color[10:5]) + 7'(p.bg_pixel[10:5]), d, 7'(G_MAX));
                b = sat_channel(7'(p.fg_color[4:0]) + 7'(p.bg_pixel[4:0]), d, 7'(RB_MAX));
                w.pixel_value = {r[4:0], g[5:0], b[4:0]};
            end
            else
            begin
                w.pixel_value = p.fg_color;
            end
        end
        return w;
    endfunction

    task automatic queue_pixel(pixel_word_t p);
        fill_job_t job;
        job.word = p;
        job.gap  = draw_gap(idle_mode);
        fill_queue.push_back(job);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DIV_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == CFG_BLEND_ENABLE)
            blend_on_model = value[0];
        else
            divisor_model = value;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic apply_setting(logic en, logic [DIV_W-1:0] div);
        write_register(CFG_BLEND_ENABLE, {7'($urandom_range(0, 127)), en});
        write_register(CFG_BLEND_DIVISOR, div);
        settings_used++;
    endtask

    task automatic drain_writes();
        do
            @(negedge clk);
        while (fill_queue.size() != 0 || drv_loaded || drv_active || pending_writes.size() != 0);
    endtask

    task automatic add_random_pixels(int count);
        pixel_word_t        p;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        int                 kind;
        for (int i = 0; i < count; i++)
        begin
            p    = make_pixel(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                if (kind < 7)
                begin
                    x = 16'($urandom_range(0, SCREEN_W - 1));
                    y = 16'($urandom_range(0, SCREEN_H - 1));
                end
                else
                begin
                    x = 16'($urandom_range(SCREEN_W - 2, SCREEN_W + 1));
                    y = 16'($urandom_range(SCREEN_H - 2, SCREEN_H + 1));
                end
                p.offset_x = x - p.rect_left;
                p.offset_y = y - p.rect_top;
            end
            if ($urandom_range(0, 7) == 0)
                p.fg_color = 16'hFFFF;
            if ($urandom_range(0, 7) == 0)
                p.bg_pixel = 16'hFFFF;
            queue_pixel(p);
        end
    endtask

    // Driver: present queued words after their drawn gap
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (drv_active && in_fire)
                drv_active = 1'b0;
            if (!drv_active && !drv_loaded && fill_queue.size() != 0)
            begin
                drv_job    = fill_queue.pop_front();
                drv_wait   = drv_job.gap;
                drv_loaded = 1'b1;
            end
            if (drv_loaded)
            begin
                if (drv_wait == 0)
                begin
                    drv_loaded            = 1'b0;
                    drv_active            = 1'b1;
                    pix_in_bus.rect_left <= drv_job.word.rect_left;
                    pix_in_bus.rect_top  <= drv_job.word.rect_top;
                    pix_in_bus.offset_x  <= drv_job.word.offset_x;
                    pix_in_bus.offset_y  <= drv_job.word.offset_y;
                    pix_in_bus.fg_color  <= drv_job.word.fg_color;
                    pix_in_bus.bg_pixel  <= drv_job.word.bg_pixel;
                end
                else
                begin
                    drv_wait--;
                end
            end
            pix_in_bus.valid <= drv_active;
        end
        else
        begin
            pix_in_bus.valid     <= 1'b0;
            pix_in_bus.rect_left <= '0;
            pix_in_bus.rect_top  <= '0;
            pix_in_bus.offset_x  <= '0;
            pix_in_bus.offset_y  <= '0;
            pix_in_bus.fg_color  <= '0;
            pix_in_bus.bg_pixel  <= '0;
        end
    end

    // Receiver: hold ready low for a drawn gap after each word, and twice for a long stretch
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                sink_taken++;
                if (sink_taken == 400 || sink_taken == 1400)
                    sink_wait = LONG_STALL;
                else
                    sink_wait = draw_gap(idle_mode);
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                pix_out_bus.ready <= 1'b0;
            end
            else
            begin
                pix_out_bus.ready <= 1'b1;
            end
        end
        else
        begin
            pix_out_bus.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        pixel_write_t got;
        pixel_write_t want;
        in_fire  <= pix_in_bus.valid && pix_in_bus.ready;
        out_fire <= pix_out_bus.valid && pix_out_bus.ready;
        if (rst_n)
        begin
            if (pix_out_bus.valid && pix_out_bus.ready)
            begin
                got.write_enable  = pix_out_bus.write_enable;
                got.pixel_address = pix_out_bus.pixel_address;
                got.pixel_value   = pix_out_bus.pixel_value;
                if (pending_writes.size() == 0)
                begin
                    $error("unexpected pixel write: %h %h %h", got.write_enable,
                           got.pixel_address, got.pixel_value);
                    fail_count++;
                end
                else
                begin
                    want = pending_writes.pop_front();
                    writes_checked++;
                    if (want.write_enable)
                        writes_on_screen++;
                    if (got.write_enable !== want.write_enable)
                    begin
                        $error("write_enable mismatch: expected %h, actual %h",
                               want.write_enable, got.write_enable);
                        fail_count++;
                    end
                    if (got.pixel_address !== want.pixel_address)
                    begin
                        $error("pixel_address mismatch: expected %h, actual %h",
                               want.pixel_address, got.pixel_address);
                        fail_count++;
                    end
                    if (got.pixel_value !== want.pixel_value)
                    begin
                        $error("pixel_value mismatch: expected %h, actual %h",
                               want.pixel_value, got.pixel_value);
                        fail_count++;
                    end
                end
            end
            if (pix_in_bus.valid && pix_in_bus.ready)
                pending_writes.push_back(predict_write(
                    make_pixel(pix_in_bus.rect_left, pix_in_bus.rect_top, pix_in_bus.offset_x,
                               pix_in_bus.offset_y, pix_in_bus.fg_color, pix_in_bus.bg_pixel),
                    blend_on_model, divisor_model));
        end
    end

    initial
    begin
        static bit               phase_en  [8] = '{1'b0, 1'b1, 1'b1, 1'b1,
                                                   1'b1, 1'b1, 1'b0, 1'b1};
        static logic [DIV_W-1:0] phase_div [8] = '{8'd2, 8'd1, 8'd2, 8'd255,
                                                   8'd0, 8'd3, 8'd0, 8'd0};
        logic [DIV_W-1:0] div;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_BLEND_ENABLE;
        cfg_bus.data         = '0;
        blend_on_model       = 1'b0;
        divisor_model        = DIVISOR_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // plain mode from reset: corners, screen edges, coordinate wrap
        queue_pixel(make_pixel(16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 16'hFFFF));
        queue_pixel(make_pixel(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'h0000));
        queue_pixel(make_pixel(16'd1000, 16'd700, 16'd23, 16'd67, 16'hA5A5, 16'h5A5A));
        queue_pixel(make_pixel(16'd1000, 16'd0, 16'd24, 16'd5, 16'h1234, 16'hFFFF));
        queue_pixel(make_pixel(16'd0, 16'd700, 16'd5, 16'd68, 16'h4321, 16'hFFFF));
        queue_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'hBEEF, 16'h0000));
        queue_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_pixel(make_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7BEF, 16'h8410));
        drain_writes();

        // blend with divisor 1: per-channel saturation
        apply_setting(1'b1, 8'd1);
        queue_pixel(make_pixel(16'd10, 16'd10, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
        queue_pixel(make_pixel(16'd10, 16'd11, 16'd0, 16'd0, 16'hF800, 16'hF800));
        queue_pixel(make_pixel(16'd10, 16'd12, 16'd0, 16'd0, 16'h07E0, 16'h07E0));
        queue_pixel(make_pixel(16'd10, 16'd13, 16'd0, 16'd0, 16'h001F, 16'h001F));
        queue_pixel(make_pixel(16'd10, 16'd14, 16'd0, 16'd0, 16'h0841, 16'h0841));
        queue_pixel(make_pixel(16'd10, 16'd15, 16'd0, 16'd0, 16'h0000, 16'h0000));
        queue_pixel(make_pixel(16'd0, 16'd800, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
        drain_writes();
        apply_setting(1'b1, 8'd255);
        queue_pixel(make_pixel(16'd20, 16'd20, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
        queue_pixel(make_pixel(16'd20, 16'd21, 16'd0, 16'd0, 16'hFFFF, 16'h0000));
        drain_writes();
        // divisor zero behaves as one
        apply_setting(1'b1, 8'd0);
        queue_pixel(make_pixel(16'd30, 16'd30, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
        queue_pixel(make_pixel(16'd30, 16'd31, 16'd0, 16'd0, 16'h1234, 16'h4321));
        drain_writes();
        apply_setting(1'b1, 8'd2);
        queue_pixel(make_pixel(16'd40, 16'd40, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
        queue_pixel(make_pixel(16'd40, 16'd41, 16'd0, 16'd0, 16'hF81F, 16'h07E0));
        drain_writes();

        for (int i = 0; i < 8; i++)
        begin
            div = (i == 7) ? 8'($urandom_range(1, 255)) : phase_div[i];
            apply_setting(phase_en[i], div);
            idle_mode = idle_mode_t'(i % 3);
            add_random_pixels(PHASE_ITEMS);
            drain_writes();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d pixel writes (%0d on screen, %0d dropped) over %0d register settings",
                 writes_checked, writes_on_screen, writes_checked - writes_on_screen,
                 settings_used);
        $display("Output side stalled twice for %0d cycles while input kept offering words",
                 LONG_STALL);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
